[hw/rtl/c2c_pkg.sv]
// Shared types and constants for the coordinate to compressed sparse column converter.
// Used by c2c_front, c2c_cmd_queue, c2c_back and the top level.
package c2c_pkg;

   localparam int COL_W = 6;
   localparam int ROW_W = 16;
   localparam int VAL_W = 32;
   localparam int PTR_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_ORIGIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_ORIGIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS   = 2'd2;

   localparam logic [COL_W-1:0] NUM_COLS_RESET = 6'd32;

   // Depth of the command queue between front and back.
   localparam int CMDQ_DEPTH = 2;

   // Result kinds.
   localparam logic KIND_POINTER = 1'b0;
   localparam logic KIND_ENTRY   = 1'b1;

   // One command describes every result that one accepted request causes:
   // an optional entry for the old pending entry, a run of column pointers,
   // an optional entry for the new pending entry, a second run of pointers
   // and an optional closing pointer.
   typedef struct packed {
      logic             ent_a;
      logic [COL_W-1:0] a_col;
      logic [ROW_W-1:0] a_row;
      logic [VAL_W-1:0] a_val;
      logic [PTR_W-1:0] base_ptr;
      logic [COL_W-1:0] r1_start;
      logic [COL_W-1:0] r1_end;
      logic             ent_b;
      logic [COL_W-1:0] b_col;
      logic [ROW_W-1:0] b_row;
      logic [VAL_W-1:0] b_val;
      logic [COL_W-1:0] r2_start;
      logic [COL_W-1:0] r2_end;
      logic             close_en;
      logic [COL_W-1:0] close_col;
      logic             dropped;
   } cmd_type;

endpackage

[hw/rtl/c2c_front.sv]
// Front part of the converter: configuration registers, request classification and
// per-matrix state. Emits one command per request that causes results. Uses c2c_pkg.
module c2c_front #(
   parameter int MAX_COLS    = 32,
   parameter int MAX_ENTRIES = 65535
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [c2c_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [c2c_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [c2c_pkg::ROW_W-1:0]       req_row,
   input  logic [c2c_pkg::ROW_W-1:0]       req_col,
   input  logic signed [c2c_pkg::VAL_W-1:0] req_value,
   input  logic                            req_last,
   input  logic                            q_full,
   output logic                            q_push,
   output c2c_pkg::cmd_type                q_cmd
);

   localparam logic [c2c_pkg::COL_W-1:0] MaxColsW = c2c_pkg::COL_W'(MAX_COLS);
   localparam logic [c2c_pkg::PTR_W:0]   MaxEntW  = (c2c_pkg::PTR_W + 1)'(MAX_ENTRIES);

   logic [c2c_pkg::ROW_W-1:0] row_origin_ff, row_origin_in;
   logic [c2c_pkg::ROW_W-1:0] col_origin_ff, col_origin_in;
   logic [c2c_pkg::COL_W-1:0] num_cols_ff, num_cols_in;

   logic [c2c_pkg::COL_W-1:0] cur_col_ff, cur_col_in;
   logic [c2c_pkg::PTR_W-1:0] entry_cnt_ff, entry_cnt_in;
   logic                      pend_vld_ff, pend_vld_in;
   logic [c2c_pkg::ROW_W-1:0] pend_row_ff, pend_row_in;
   logic [c2c_pkg::VAL_W-1:0] pend_sum_ff, pend_sum_in;
   logic                      err_ff, err_in;
   logic                      started_ff, started_in;

   logic                      accept;
   logic [c2c_pkg::COL_W-1:0] ncols;
   logic [c2c_pkg::ROW_W-1:0] rrow;
   logic [c2c_pkg::ROW_W-1:0] rcol_full;
   logic [c2c_pkg::COL_W-1:0] rcol;
   logic                      bad_pos;
   logic                      dup;
   logic                      cap_full;
   logic                      new_ent;
   logic                      err_now;
   logic [c2c_pkg::VAL_W:0]   sum_wide;
   logic [c2c_pkg::VAL_W-1:0] sat_sum;
   logic [c2c_pkg::COL_W-1:0] cur_after;
   logic                      started_after;
   logic [c2c_pkg::COL_W-1:0] s2;
   c2c_pkg::cmd_type          cmd;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      row_origin_in = row_origin_ff;
      col_origin_in = col_origin_ff;
      num_cols_in   = num_cols_ff;
      if (csr_valid) begin
         case (csr_index)
            c2c_pkg::CSR_ROW_ORIGIN: row_origin_in = csr_data;
            c2c_pkg::CSR_COL_ORIGIN: col_origin_in = csr_data;
            c2c_pkg::CSR_NUM_COLS:   num_cols_in   = csr_data[c2c_pkg::COL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (num_cols_ff == '0) begin
         ncols = c2c_pkg::COL_W'(1);
      end else if (num_cols_ff > MaxColsW) begin
         ncols = MaxColsW;
      end else begin
         ncols = num_cols_ff;
      end
   end

   // Classification of the request against the current matrix state.
   always_comb begin
      rrow      = req_row - row_origin_ff;
      rcol_full = req_col - col_origin_ff;
      rcol      = rcol_full[c2c_pkg::COL_W-1:0];
      bad_pos   = (req_col < col_origin_ff) ||
                  (rcol_full >= {{(c2c_pkg::ROW_W - c2c_pkg::COL_W){1'b0}}, ncols}) ||
                  (started_ff && rcol < cur_col_ff);
      dup       = !bad_pos && started_ff && rcol == cur_col_ff && pend_vld_ff &&
                  rrow == pend_row_ff;
      cap_full  = ({1'b0, entry_cnt_ff} + {{c2c_pkg::PTR_W{1'b0}}, pend_vld_ff}) >= MaxEntW;
      new_ent   = !err_ff && !bad_pos && !dup && !cap_full;
      err_now   = err_ff || (!bad_pos && !dup && cap_full) || bad_pos;
      if (err_ff) begin
         err_now = 1'b1;
      end
      sum_wide  = {pend_sum_ff[c2c_pkg::VAL_W-1], pend_sum_ff} +
                  {req_value[c2c_pkg::VAL_W-1], $unsigned(req_value)};
      if (sum_wide[c2c_pkg::VAL_W] != sum_wide[c2c_pkg::VAL_W-1]) begin
         sat_sum = sum_wide[c2c_pkg::VAL_W] ? {1'b1, {(c2c_pkg::VAL_W-1){1'b0}}}
                                            : {1'b0, {(c2c_pkg::VAL_W-1){1'b1}}};
      end else begin
         sat_sum = sum_wide[c2c_pkg::VAL_W-1:0];
      end
   end

   // A duplicate only counts when no error was seen before.
   logic dup_ok;
   assign dup_ok = dup && !err_ff;

   always_comb begin
      cur_after     = new_ent ? rcol : cur_col_ff;
      started_after = started_ff || new_ent;
      s2            = started_after ? cur_after + c2c_pkg::COL_W'(1) : '0;

      cmd.ent_a     = pend_vld_ff && (new_ent || req_last);
      cmd.a_col     = cur_col_ff;
      cmd.a_row     = pend_row_ff;
      cmd.a_val     = dup_ok ? sat_sum : pend_sum_ff;
      cmd.base_ptr  = entry_cnt_ff;
      cmd.r1_start  = started_ff ? cur_col_ff + c2c_pkg::COL_W'(1) : '0;
      cmd.r1_end    = new_ent ? rcol + c2c_pkg::COL_W'(1) : '0;
      cmd.ent_b     = new_ent && req_last;
      cmd.b_col     = rcol;
      cmd.b_row     = rrow;
      cmd.b_val     = $unsigned(req_value);
      cmd.r2_start  = s2;
      cmd.r2_end    = req_last ? ncols : '0;
      cmd.close_en  = req_last;
      cmd.close_col = (s2 < ncols) ? ncols : s2;
      cmd.dropped   = err_now;
   end

   assign q_cmd  = cmd;
   assign q_push = accept && (cmd.ent_a || cmd.ent_b || req_last ||
                              (cmd.r1_start < cmd.r1_end));

   always_comb begin
      cur_col_in   = cur_col_ff;
      entry_cnt_in = entry_cnt_ff;
      pend_vld_in  = pend_vld_ff;
      pend_row_in  = pend_row_ff;
      pend_sum_in  = pend_sum_ff;
      err_in       = err_ff;
      started_in   = started_ff;
      if (accept) begin
         if (req_last) begin
            cur_col_in   = '0;
            entry_cnt_in = '0;
            pend_vld_in  = 1'b0;
            pend_row_in  = '0;
            pend_sum_in  = '0;
            err_in       = 1'b0;
            started_in   = 1'b0;
         end else begin
            err_in       = err_now;
            cur_col_in   = cur_after;
            started_in   = started_after;
            entry_cnt_in = entry_cnt_ff + (cmd.ent_a ? c2c_pkg::PTR_W'(1) : '0);
            if (new_ent) begin
               pend_vld_in = 1'b1;
               pend_row_in = rrow;
               pend_sum_in = $unsigned(req_value);
            end else if (dup_ok) begin
               pend_sum_in = sat_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_origin_ff <= '0;
         col_origin_ff <= '0;
         num_cols_ff   <= c2c_pkg::NUM_COLS_RESET;
         cur_col_ff    <= '0;
         entry_cnt_ff  <= '0;
         pend_vld_ff   <= 1'b0;
         pend_row_ff   <= '0;
         pend_sum_ff   <= '0;
         err_ff        <= 1'b0;
         started_ff    <= 1'b0;
      end else begin
         row_origin_ff <= row_origin_in;
         col_origin_ff <= col_origin_in;
         num_cols_ff   <= num_cols_in;
         cur_col_ff    <= cur_col_in;
         entry_cnt_ff  <= entry_cnt_in;
         pend_vld_ff   <= pend_vld_in;
         pend_row_ff   <= pend_row_in;
         pend_sum_ff   <= pend_sum_in;
         err_ff        <= err_in;
         started_ff    <= started_in;
      end
   end

endmodule

[hw/rtl/c2c_cmd_queue.sv]
// Short command queue that decouples the converter's front and back parts.
// Holds c2c_pkg::cmd_type entries in a small register array.
module c2c_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  c2c_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output c2c_pkg::cmd_type head
);

   localparam int Depth = c2c_pkg::CMDQ_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthW  = CntW'(Depth);

   c2c_pkg::cmd_type mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == DepthW);
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/c2c_back.sv]
// Back part of the converter: a sequencer that expands one command into its results,
// one per cycle unless stalled, into a registered result stage. Uses c2c_pkg.
module c2c_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  c2c_pkg::cmd_type                  q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [c2c_pkg::COL_W-1:0]         rsp_column,
   output logic [c2c_pkg::PTR_W-1:0]         rsp_pointer,
   output logic [c2c_pkg::ROW_W-1:0]         rsp_entry_row,
   output logic signed [c2c_pkg::VAL_W-1:0]  rsp_entry_value,
   output logic                              rsp_dropped,
   output logic                              rsp_final_res
);

   // Phase codes, in the order results leave for one command.
   localparam logic [2:0] PH_A    = 3'd1;
   localparam logic [2:0] PH_R1   = 3'd2;
   localparam logic [2:0] PH_B    = 3'd3;
   localparam logic [2:0] PH_R2   = 3'd4;
   localparam logic [2:0] PH_CL   = 3'd5;
   localparam logic [2:0] PH_DONE = 3'd6;

   function automatic logic [2:0] first_phase(input c2c_pkg::cmd_type c,
                                              input logic [2:0] from);
      logic [2:0] ph;
      ph = PH_DONE;
      if (from <= PH_CL && c.close_en) ph = PH_CL;
      if (from <= PH_R2 && c.r2_start < c.r2_end) ph = PH_R2;
      if (from <= PH_B && c.ent_b) ph = PH_B;
      if (from <= PH_R1 && c.r1_start < c.r1_end) ph = PH_R1;
      if (from <= PH_A && c.ent_a) ph = PH_A;
      return ph;
   endfunction

   c2c_pkg::cmd_type           cmd_ff, cmd_in;
   logic [2:0]                 ph_ff, ph_in;
   logic [c2c_pkg::COL_W-1:0]  col_ff, col_in;
   logic [c2c_pkg::PTR_W-1:0]  ptr_ff, ptr_in;

   logic                       out_vld_ff, out_vld_in;
   logic                       out_kind_ff, out_kind_in;
   logic [c2c_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic [c2c_pkg::PTR_W-1:0]  out_ptr_ff, out_ptr_in;
   logic [c2c_pkg::ROW_W-1:0]  out_row_ff, out_row_in;
   logic [c2c_pkg::VAL_W-1:0]  out_val_ff, out_val_in;
   logic                       out_drop_ff, out_drop_in;
   logic                       out_fin_ff, out_fin_in;

   logic                       adv;
   logic                       stay;
   logic [2:0]                 ph_next;
   logic [c2c_pkg::COL_W:0]    col_inc;
   logic                       load;
   c2c_pkg::cmd_type           sel_cmd;

   assign adv     = (ph_ff != PH_DONE) && (!out_vld_ff || !rsp_stall);
   assign col_inc = {1'b0, col_ff} + (c2c_pkg::COL_W + 1)'(1);

   always_comb begin
      stay    = 1'b0;
      ph_next = ph_ff;
      if (adv) begin
         case (ph_ff)
            PH_A:  ph_next = first_phase(cmd_ff, PH_R1);
            PH_R1: begin
               stay    = col_inc < {1'b0, cmd_ff.r1_end};
               ph_next = stay ? PH_R1 : first_phase(cmd_ff, PH_B);
            end
            PH_B:  ph_next = first_phase(cmd_ff, PH_R2);
            PH_R2: begin
               stay    = col_inc < {1'b0, cmd_ff.r2_end};
               ph_next = stay ? PH_R2 : first_phase(cmd_ff, PH_CL);
            end
            PH_CL: ph_next = PH_DONE;
            default: ph_next = PH_DONE;
         endcase
      end
      load    = (ph_next == PH_DONE) && !q_empty;
      q_pop   = load;
      sel_cmd = load ? q_head : cmd_ff;
      cmd_in  = sel_cmd;
      ph_in   = load ? first_phase(q_head, PH_A) : ph_next;
      // The column counter only moves when a result leaves or a command is loaded;
      // a stalled run keeps its place.
      if (stay) begin
         col_in = col_inc[c2c_pkg::COL_W-1:0];
      end else if (!adv && !load) begin
         col_in = col_ff;
      end else if (ph_in == PH_R1) begin
         col_in = sel_cmd.r1_start;
      end else begin
         col_in = sel_cmd.r2_start;
      end
      if (load) begin
         ptr_in = q_head.base_ptr;
      end else if (adv && (ph_ff == PH_A || ph_ff == PH_B)) begin
         ptr_in = ptr_ff + c2c_pkg::PTR_W'(1);
      end else begin
         ptr_in = ptr_ff;
      end
   end

   // Result register.
   always_comb begin
      out_vld_in  = out_vld_ff && rsp_stall;
      out_kind_in = out_kind_ff;
      out_col_in  = out_col_ff;
      out_ptr_in  = out_ptr_ff;
      out_row_in  = out_row_ff;
      out_val_in  = out_val_ff;
      out_drop_in = out_drop_ff;
      out_fin_in  = out_fin_ff;
      if (adv) begin
         out_vld_in  = 1'b1;
         out_kind_in = c2c_pkg::KIND_POINTER;
         out_col_in  = col_ff;
         out_ptr_in  = ptr_ff;
         out_row_in  = '0;
         out_val_in  = '0;
         out_drop_in = cmd_ff.dropped;
         out_fin_in  = 1'b0;
         case (ph_ff)
            PH_A: begin
               out_kind_in = c2c_pkg::KIND_ENTRY;
               out_col_in  = cmd_ff.a_col;
               out_row_in  = cmd_ff.a_row;
               out_val_in  = cmd_ff.a_val;
            end
            PH_B: begin
               out_kind_in = c2c_pkg::KIND_ENTRY;
               out_col_in  = cmd_ff.b_col;
               out_row_in  = cmd_ff.b_row;
               out_val_in  = cmd_ff.b_val;
            end
            PH_CL: begin
               out_col_in = cmd_ff.close_col;
               out_fin_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      col_ff      <= col_in;
      ptr_ff      <= ptr_in;
      out_kind_ff <= out_kind_in;
      out_col_ff  <= out_col_in;
      out_ptr_ff  <= out_ptr_in;
      out_row_ff  <= out_row_in;
      out_val_ff  <= out_val_in;
      out_drop_ff <= out_drop_in;
      out_fin_ff  <= out_fin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff      <= PH_DONE;
         out_vld_ff <= 1'b0;
      end else begin
         ph_ff      <= ph_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_column      = out_col_ff;
   assign rsp_pointer     = out_ptr_ff;
   assign rsp_entry_row   = out_row_ff;
   assign rsp_entry_value = $signed(out_val_ff);
   assign rsp_dropped     = out_drop_ff;
   assign rsp_final_res   = out_fin_ff;

endmodule

[hw/rtl/coo_to_csc_converter_unit.sv]
// Coordinate to compressed sparse column converter, top level.
// A request's first result passes the command queue, the back part's command register and
// the result register. Throughput: one result per cycle from the back sequencer unless stalled;
// a request with k results holds it until all k have left, and requests enter at one per
// cycle while the queue has room. Reset (synchronous, active high) clears all matrix state,
// the queue and the result stage, and sets row_origin = 0, col_origin = 0, num_cols = 32.
module coo_to_csc_converter_unit #(
   parameter int MAX_COLS    = 32,
   parameter int MAX_ENTRIES = 65535
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [c2c_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [c2c_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [c2c_pkg::ROW_W-1:0]         req_row,
   input  logic [c2c_pkg::ROW_W-1:0]         req_col,
   input  logic signed [c2c_pkg::VAL_W-1:0]  req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [c2c_pkg::COL_W-1:0]         rsp_column,
   output logic [c2c_pkg::PTR_W-1:0]         rsp_pointer,
   output logic [c2c_pkg::ROW_W-1:0]         rsp_entry_row,
   output logic signed [c2c_pkg::VAL_W-1:0]  rsp_entry_value,
   output logic                              rsp_dropped,
   output logic                              rsp_final_res
);

   // The front part owns the configuration registers and all per-matrix state.
   // It classifies each request the cycle it arrives (out of range, duplicate to be
   // summed, or new entry), updates the state at once and, when the request causes
   // results, pushes a single command describing them into the queue.
   c2c_pkg::cmd_type q_cmd;
   c2c_pkg::cmd_type q_head;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;

   c2c_front #(
      .MAX_COLS    (MAX_COLS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_value (req_value),
      .req_last  (req_last),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // The queue lets the front keep taking requests while the back is still
   // working through a long run of column pointers.
   c2c_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   // The back part walks each command phase by phase: flushed entry, pointer run
   // for empty columns, the new entry when the matrix closes, the trailing pointer
   // run and the closing pointer. It loads the next command in the same cycle that
   // the last result of the current one leaves, so results stream without gaps.
   c2c_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_column      (rsp_column),
      .rsp_pointer     (rsp_pointer),
      .rsp_entry_row   (rsp_entry_row),
      .rsp_entry_value (rsp_entry_value),
      .rsp_dropped     (rsp_dropped),
      .rsp_final_res   (rsp_final_res)
   );

`ifndef SYNTH
   // The front never pushes into a full queue: it stalls requests first.
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("command pushed into a full queue");

   // The closing result of a matrix is always a column pointer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_res) |-> (rsp_kind == c2c_pkg::KIND_POINTER))
      else $error("closing result is not a column pointer");

   // Nothing is presented in the cycle after reset.
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A command is only taken from the queue when one is there.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("pop from an empty command queue");
`endif

endmodule

[verif/tb_coo_to_csc_converter_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for coo_to_csc_converter_unit: a queue-fed driver, a checking
// monitor and an in-bench predictor of the column-pointer and entry stream.
// Depends on c2c_pkg and the converter RTL only.
module tb_coo_to_csc_converter_unit;
   import c2c_pkg::*;

   localparam int MAX_COLS    = 32;
   localparam int MAX_ENTRIES = 65535;
   localparam int QUIET_LIMIT = 4000;
   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;

   // One matrix element waiting to be offered on the request channel. When wait_drain
   // is set, the driver holds it back until every predicted result has arrived.
   typedef struct {
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
      logic [VAL_W-1:0] value;
      logic             last;
      logic             wait_drain;
   } elem_type;

   // One word of the compressed sparse column stream.
   typedef struct {
      logic                    kind;
      logic [COL_W-1:0]        column;
      logic [PTR_W-1:0]        pointer;
      logic [ROW_W-1:0]        entry_row;
      logic signed [VAL_W-1:0] entry_value;
      logic                    dropped;
      logic                    final_res;
   } csc_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_ROW_ORIGIN;
   logic [CSR_DATA_W-1:0]    csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [ROW_W-1:0]         req_row = '0;
   logic [ROW_W-1:0]         req_col = '0;
   logic signed [VAL_W-1:0]  req_value = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_kind;
   logic [COL_W-1:0]         rsp_column;
   logic [PTR_W-1:0]         rsp_pointer;
   logic [ROW_W-1:0]         rsp_entry_row;
   logic signed [VAL_W-1:0]  rsp_entry_value;
   logic                     rsp_dropped;
   logic                     rsp_final_res;

   // Elements not yet offered, and stream words predicted but not yet received.
   elem_type     element_queue[$];
   csc_word_type csc_words_due[$];

   // Idling percentages for the current phase.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   int mismatch_count = 0;
   int result_index = 0;
   int quiet_cycles = 0;

   // Register copies, updated when a write is accepted.
   logic [15:0]      cfg_row_origin = 16'd0;
   logic [15:0]      cfg_col_origin = 16'd0;
   logic [COL_W-1:0] cfg_num_cols = NUM_COLS_RESET;

   // Per-matrix state of the predictor.
   int                      mx_col = 0;
   int                      mx_entries = 0;
   bit                      mx_pending = 1'b0;
   logic [ROW_W-1:0]        mx_row = '0;
   logic signed [VAL_W-1:0] mx_sum = '0;
   bit                      mx_error = 1'b0;
   bit                      mx_started = 1'b0;

   coo_to_csc_converter_unit #(
      .MAX_COLS    (MAX_COLS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_column      (rsp_column),
      .rsp_pointer     (rsp_pointer),
      .rsp_entry_row   (rsp_entry_row),
      .rsp_entry_value (rsp_entry_value),
      .rsp_dropped     (rsp_dropped),
      .rsp_final_res   (rsp_final_res)
   );

   always #10 clock = ~clock;

   // Column count in force: zero behaves as one column, anything past the build limit
   // is clipped to it.
   function automatic int cols_in_use();
      if (cfg_num_cols == 0) return 1;
      if (cfg_num_cols > MAX_COLS) return MAX_COLS;
      return cfg_num_cols;
   endfunction

   function automatic void emit_word(input logic kind, input int column, input int pointer,
                                     input logic [ROW_W-1:0] row,
                                     input logic [VAL_W-1:0] value, input logic fin);
      csc_word_type w;
      w.kind = kind;
      w.column = column[COL_W-1:0];
      w.pointer = pointer[PTR_W-1:0];
      w.entry_row = row;
      w.entry_value = value;
      w.dropped = mx_error;
      w.final_res = fin;
      csc_words_due.push_back(w);
   endfunction

   // The entry being accumulated goes out once its row or column changes.
   function automatic void close_entry();
      if (mx_pending) begin
         emit_word(KIND_ENTRY, mx_col, mx_entries, mx_row, mx_sum, 1'b0);
         mx_entries++;
         mx_pending = 1'b0;
      end
   endfunction

   // Predicts every stream word that one accepted element causes.
   function automatic void convert_element(input logic [ROW_W-1:0] row,
                                           input logic [ROW_W-1:0] col,
                                           input logic [VAL_W-1:0] value,
                                           input logic last);
      logic [ROW_W-1:0] rrow;
      int rcol;
      int ncols;
      int nxt;
      bit bad;
      bit dup;
      longint total;
      ncols = cols_in_use();
      if (!mx_error) begin
         // Row offsets wrap; a column below the origin gives a negative offset.
         rrow = row - cfg_row_origin;
         rcol = int'(col) - int'(cfg_col_origin);
         bad = (rcol < 0) || (rcol >= ncols) || (mx_started && rcol < mx_col);
         dup = !bad && mx_started && rcol == mx_col && mx_pending && rrow == mx_row;
         if (!bad && !dup && mx_entries + int'(mx_pending) >= MAX_ENTRIES) bad = 1'b1;
         if (bad) begin
            mx_error = 1'b1;
         end else if (dup) begin
            total = longint'(mx_sum) + longint'($signed(value));
            if (total > SUM_MAX) total = SUM_MAX;
            else if (total < SUM_MIN) total = SUM_MIN;
            mx_sum = total[VAL_W-1:0];
         end else begin
            close_entry();
            nxt = mx_started ? mx_col + 1 : 0;
            while (nxt <= rcol) begin
               emit_word(KIND_POINTER, nxt, mx_entries, '0, '0, 1'b0);
               nxt++;
            end
            mx_col = rcol;
            mx_started = 1'b1;
            mx_pending = 1'b1;
            mx_row = rrow;
            mx_sum = value;
         end
      end
      if (last) begin
         // Flush: the pending entry, remaining column pointers, then the closing one.
         close_entry();
         nxt = mx_started ? mx_col + 1 : 0;
         while (nxt < ncols) begin
            emit_word(KIND_POINTER, nxt, mx_entries, '0, '0, 1'b0);
            nxt++;
         end
         emit_word(KIND_POINTER, nxt, mx_entries, '0, '0, 1'b1);
         mx_col = 0;
         mx_entries = 0;
         mx_pending = 1'b0;
         mx_row = '0;
         mx_sum = '0;
         mx_error = 1'b0;
         mx_started = 1'b0;
      end
   endfunction

   function automatic void queue_element(input logic [ROW_W-1:0] row,
                                         input logic [ROW_W-1:0] col,
                                         input logic [VAL_W-1:0] value,
                                         input logic last, input logic wait_drain);
      elem_type e;
      e.row = row;
      e.col = col;
      e.value = value;
      e.last = last;
      e.wait_drain = wait_drain;
      element_queue.push_back(e);
   endfunction

   // Queues one matrix: columns rise, rows often repeat so that duplicates get summed.
   // About one matrix in five gets a single broken element (column going backwards,
   // past the column count, or anywhere at all) to exercise the sticky drop.
   function automatic int queue_random_matrix();
      int ncols;
      int nel;
      int rel_col;
      int rel_row;
      int broken_at;
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
      logic [VAL_W-1:0] value;
      ncols = cols_in_use();
      nel = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      broken_at = ($urandom_range(4) == 0) ? $urandom_range(0, nel - 1) : -1;
      rel_col = $urandom_range(0, 2);
      if (rel_col > ncols - 1) rel_col = ncols - 1;
      rel_row = $urandom_range(0, 15);
      for (int i = 0; i < nel; i++) begin
         if (i > 0) begin
            if ($urandom_range(2) == 0) begin
               rel_col = rel_col + $urandom_range(1, 3);
               if (rel_col > ncols - 1) rel_col = ncols - 1;
            end
            if ($urandom_range(2) != 0)
               rel_row = ($urandom_range(7) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 15);
         end
         row = cfg_row_origin + rel_row[15:0];
         col = cfg_col_origin + rel_col[15:0];
         if (i == broken_at) begin
            case ($urandom_range(2))
               0: col = 16'($urandom_range(0, 65535));
               1: col = cfg_col_origin + ncols[15:0];
               default: col = cfg_col_origin + rel_col[15:0] - 16'd1;
            endcase
         end
         case ($urandom_range(7))
            0: value = 32'h7FFF_FFFF;
            1: value = 32'h8000_0000;
            2: value = $urandom_range(0, 255);
            default: value = $urandom;
         endcase
         queue_element(row, col, value, i == nel - 1, $urandom_range(39) == 0);
      end
      return nel;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at result %0d: %s", result_index, what);
      mismatch_count++;
   endtask

   // Waits until every element has gone in and every predicted word has come out.
   // The check is made at the falling edge, when the driver's updates of the rising
   // edge have settled.
   task automatic wait_for_idle();
      do @(negedge clock);
      while (element_queue.size() != 0 || req_valid || csc_words_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_index <= index;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_ROW_ORIGIN: cfg_row_origin = data;
         CSR_COL_ORIGIN: cfg_col_origin = data;
         CSR_NUM_COLS:   cfg_num_cols = data[COL_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Three rounds, each with a fresh random register setting and a batch of matrices.
   task automatic run_random_phase(input int send_pct, input int stall_pct);
      int made;
      logic [COL_W-1:0] ncols;
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      repeat (3) begin
         wait_for_idle();
         case ($urandom_range(3))
            0: write_register(CSR_ROW_ORIGIN, 16'h0000);
            1: write_register(CSR_ROW_ORIGIN, 16'hFFFF);
            default: write_register(CSR_ROW_ORIGIN, 16'($urandom_range(0, 65535)));
         endcase
         case ($urandom_range(3))
            0: write_register(CSR_COL_ORIGIN, 16'h0000);
            1: write_register(CSR_COL_ORIGIN, 16'hFFE0);
            default: write_register(CSR_COL_ORIGIN, 16'($urandom_range(0, 65535)));
         endcase
         case ($urandom_range(6))
            0: ncols = 6'd1;
            1: ncols = 6'd32;
            2: ncols = 6'd0;
            3: ncols = ($urandom_range(1) == 0) ? 6'd63 : 6'd33;
            default: ncols = 6'($urandom_range(2, 31));
         endcase
         // Upper data bits carry noise; the register keeps only its own width.
         write_register(CSR_NUM_COLS, {10'($urandom), ncols});
         made = 0;
         while (made < 18) made += queue_random_matrix();
      end
   endtask

   // Request driver. An element is accepted when valid is high and stall low at the
   // edge; the prediction is made right then from the values on the pins. A new
   // element is only put up when nothing is held, so valid never follows stall.
   always @(posedge clock) begin : request_driver
      elem_type nxt_elem;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) convert_element(req_row, req_col, req_value, req_last);
         if (!req_valid || !req_stall) begin
            if (element_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(element_queue[0].wait_drain && csc_words_due.size() != 0)) begin
               nxt_elem = element_queue.pop_front();
               req_valid <= 1'b1;
               req_row <= nxt_elem.row;
               req_col <= nxt_elem.col;
               req_value <= nxt_elem.value;
               req_last <= nxt_elem.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: random stall, and every accepted word checked field by field
   // against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      csc_word_type want;
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (csc_words_due.size() == 0) begin
            report_mismatch("result arrived with nothing predicted");
         end else begin
            want = csc_words_due.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, predicted %0d", rsp_kind, want.kind));
            if (rsp_column !== want.column)
               report_mismatch($sformatf("column %0d, predicted %0d",
                                         rsp_column, want.column));
            if (rsp_pointer !== want.pointer)
               report_mismatch($sformatf("pointer %0d, predicted %0d",
                                         rsp_pointer, want.pointer));
            if (rsp_entry_row !== want.entry_row)
               report_mismatch($sformatf("entry_row %0d, predicted %0d",
                                         rsp_entry_row, want.entry_row));
            if (rsp_entry_value !== want.entry_value)
               report_mismatch($sformatf("entry_value %h, predicted %h",
                                         rsp_entry_value, want.entry_value));
            if (rsp_dropped !== want.dropped)
               report_mismatch($sformatf("dropped %0d, predicted %0d",
                                         rsp_dropped, want.dropped));
            if (rsp_final_res !== want.final_res)
               report_mismatch($sformatf("final_res %0d, predicted %0d",
                                         rsp_final_res, want.final_res));
         end
         result_index++;
      end
   end

   // Watchdog: any handshake counts as progress, except a result that nothing
   // predicted, so a runaway result stream still ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (csr_valid && csr_ready) ||
          (rsp_valid && !rsp_stall && csc_words_due.size() != 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed matrices under the reset setting (origins zero, 32 columns).
      // Positive and negative saturation of duplicate sums, a plain duplicate sum,
      // skipped empty columns, the top row and the last column.
      queue_element(16'd0, 16'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_element(16'd0, 16'd0, 32'h0000_0001, 1'b0, 1'b0);
      queue_element(16'd7, 16'd0, 32'h8000_0000, 1'b0, 1'b0);
      queue_element(16'd7, 16'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_element(16'd9, 16'd0, 32'h0001_0000, 1'b0, 1'b0);
      queue_element(16'd9, 16'd0, 32'h0000_8000, 1'b0, 1'b0);
      queue_element(16'hFFFF, 16'd3, 32'h1234_5678, 1'b0, 1'b0);
      queue_element(16'd2, 16'd31, 32'hFFFF_0000, 1'b1, 1'b0);
      // Column going backwards drops the rest; the flush still happens on a dropped
      // element. The first element waits for the previous matrix to drain completely.
      queue_element(16'd0, 16'd4, 32'h0000_0100, 1'b0, 1'b1);
      queue_element(16'd1, 16'd2, 32'h0000_0200, 1'b0, 1'b0);
      queue_element(16'd2, 16'd5, 32'h0000_0300, 1'b0, 1'b0);
      queue_element(16'd3, 16'd6, 32'h0000_0400, 1'b1, 1'b0);
      // Column at the column count, then the highest possible column with last set.
      queue_element(16'd0, 16'd32, 32'h0000_0001, 1'b0, 1'b0);
      queue_element(16'd0, 16'd0, 32'h0000_0001, 1'b1, 1'b0);
      queue_element(16'd5, 16'hFFFF, 32'hAAAA_5555, 1'b1, 1'b0);
      wait_for_idle();

      // Nonzero origins: row below the origin wraps, column below the origin is dropped.
      write_register(CSR_ROW_ORIGIN, 16'h8000);
      write_register(CSR_COL_ORIGIN, 16'd100);
      write_register(CSR_NUM_COLS, 16'hFFC5);
      queue_element(16'h8003, 16'd101, 32'h0002_0000, 1'b0, 1'b0);
      queue_element(16'h7FFF, 16'd101, 32'h5555_AAAA, 1'b0, 1'b0);
      queue_element(16'h8000, 16'd99, 32'h0000_0001, 1'b1, 1'b0);
      wait_for_idle();

      // A column count of zero behaves as one column.
      write_register(CSR_NUM_COLS, 16'd0);
      queue_element(16'h8001, 16'd100, 32'h0000_0010, 1'b0, 1'b0);
      queue_element(16'h8001, 16'd101, 32'h0000_0020, 1'b1, 1'b0);
      wait_for_idle();

      // A column count above the build limit is clipped to it.
      write_register(CSR_ROW_ORIGIN, 16'd0);
      write_register(CSR_COL_ORIGIN, 16'd0);
      write_register(CSR_NUM_COLS, 16'd63);
      queue_element(16'd1, 16'd31, 32'h0000_0030, 1'b0, 1'b0);
      queue_element(16'd1, 16'd32, 32'h0000_0040, 1'b1, 1'b0);
      wait_for_idle();

      // Column count lowered inside a matrix, below the current column: the pending entry
      // is flushed and only the closing pointer follows, one past the current column.
      write_register(CSR_NUM_COLS, 16'd32);
      queue_element(16'd1, 16'd10, 32'h0000_0050, 1'b0, 1'b0);
      wait_for_idle();
      write_register(CSR_NUM_COLS, 16'd5);
      queue_element(16'd0, 16'd10, 32'h0000_0060, 1'b1, 1'b0);
      wait_for_idle();

      // Column count lowered inside a matrix but still above the current column.
      write_register(CSR_NUM_COLS, 16'd32);
      queue_element(16'd1, 16'd10, 32'h0000_0070, 1'b0, 1'b0);
      wait_for_idle();
      write_register(CSR_NUM_COLS, 16'd20);
      queue_element(16'd2, 16'd10, 32'h0000_0080, 1'b1, 1'b0);
      wait_for_idle();

      // Random matrices under each idling pattern.
      run_random_phase(0, 0);
      run_random_phase(78, 0);
      run_random_phase(0, 78);
      run_random_phase(9, 9);

      wait_for_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && csc_words_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
